// ===== src/frdt_pkg.sv =====
// Shared types, constants and fixed-point helpers of the frame damage rectangle tracker.
// No dependencies; every other file of the block but frdt_ram imports this package.
package frdt_pkg;

    localparam int MAX_ENTITIES  = 64;
    localparam int FRACTION_BITS = 4;
    localparam int IDX_W         = $clog2(MAX_ENTITIES);
    localparam int CNT_W         = $clog2(MAX_ENTITIES + 1);
    localparam int RAM_DEPTH     = 2 * MAX_ENTITIES;
    localparam int RAM_AW        = IDX_W + 1;
    localparam int QUEUE_DEPTH   = 4;
    localparam int Q_PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int COORD_W       = 14;
    localparam int IN_DATA_W     = 200;
    localparam int IN_USER_W     = 3;
    localparam int OUT_DATA_W    = 56;
    localparam int OUT_USER_W    = 2;
    localparam int CFG_IDX_W     = 2;

    localparam logic [COORD_W-1:0] WIDTH_RESET  = 14'd1920;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 14'd1080;

    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        ACT_BEGIN = 2'd0,
        ACT_HINT  = 2'd1,
        ACT_CMD   = 2'd2,
        ACT_END   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HINT,
        ST_LOOK_RD,
        ST_LOOK_CMP,
        ST_CMD_FIN,
        ST_SW_RD,
        ST_SW_CMP,
        ST_END_FIN
    } state_t;

    typedef struct packed {
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
    } box_t;

    typedef struct packed {
        logic [31:0] key;
        box_t        box;
        logic [31:0] depth;
        logic [31:0] payload;
        logic [7:0]  kind;
        logic [15:0] opacity;
    } entry_t;

    typedef struct packed {
        action_t action;
        logic    repaint_all;
        entry_t  ent;
    } item_t;

    typedef struct packed {
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
        logic               valid;
        logic               last;
        logic               ovf;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } surface_t;

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        if (v > 21'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -21'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] fx_floor(input logic signed [19:0] v);
        logic signed [20:0] e;
        e = {v[19], v};
        return sat16(e >>> FRACTION_BITS);
    endfunction

    function automatic logic signed [15:0] fx_ceil(input logic signed [19:0] v);
        logic signed [20:0] e;
        e = {v[19], v} + $signed(21'((1 << FRACTION_BITS) - 1));
        return sat16(e >>> FRACTION_BITS);
    endfunction

    function automatic logic [COORD_W-1:0] clamp_edge(input logic signed [15:0] v,
                                                      input logic [COORD_W-1:0] hi);
        if (v < 16'sd0) begin
            return '0;
        end else if (v > $signed({2'b00, hi})) begin
            return hi;
        end
        return v[COORD_W-1:0];
    endfunction

    // Clamps a box to the surface; valid is set when the clamped box is not empty.
    function automatic result_t clamp_box(input box_t b, input surface_t s);
        result_t r;
        r.min_x = clamp_edge(b.x0, s.width);
        r.max_x = clamp_edge(b.x1, s.width);
        r.min_y = clamp_edge(b.y0, s.height);
        r.max_y = clamp_edge(b.y1, s.height);
        r.valid = (r.max_x > r.min_x) && (r.max_y > r.min_y);
        r.last  = 1'b0;
        r.ovf   = 1'b0;
        return r;
    endfunction

endpackage

// ===== src/frdt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module frdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/frdt_front.sv =====
// Front end: unpacks an input word and converts its rectangle to ordered integer edges.
// Depends on frdt_pkg.
module frdt_front (
    input  logic [frdt_pkg::IN_DATA_W-1:0] in_data,
    input  logic [frdt_pkg::IN_USER_W-1:0] in_user,
    output frdt_pkg::item_t                item
);
    import frdt_pkg::*;

    logic signed [19:0] ax, ay, bx, by;

    assign ax = in_data[51:32];
    assign ay = in_data[71:52];
    assign bx = in_data[91:72];
    assign by = in_data[111:92];

    always_comb begin
        item.action       = action_t'(in_user[1:0]);
        item.repaint_all  = in_user[2];
        item.ent.key      = in_data[31:0];
        // Each axis is ordered first, then the low edge floors and the high edge ceils.
        item.ent.box.x0   = fx_floor((ax < bx) ? ax : bx);
        item.ent.box.x1   = fx_ceil((ax > bx) ? ax : bx);
        item.ent.box.y0   = fx_floor((ay < by) ? ay : by);
        item.ent.box.y1   = fx_ceil((ay > by) ? ay : by);
        item.ent.depth    = in_data[143:112];
        item.ent.kind     = in_data[151:144];
        item.ent.payload  = in_data[183:152];
        item.ent.opacity  = in_data[199:184];
    end

endmodule

// ===== src/frdt_queue.sv =====
// Short queue of converted items between the front end and the sequencer.
// Depends on frdt_pkg.
module frdt_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  frdt_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output frdt_pkg::item_t head
);
    import frdt_pkg::*;

    item_t              mem_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]   level_reg;

    assign full      = (level_reg == (Q_PTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (level_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/frdt_back.sv =====
// Sequencer: lookups, stores and the end-of-frame sweep over the entity RAM, plus the
// output register. Depends on frdt_pkg and frdt_ram.
module frdt_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  frdt_pkg::surface_t surf,
    input  logic               q_not_empty,
    input  frdt_pkg::item_t    q_head,
    output logic               q_pop,
    output frdt_pkg::result_t  out_result,
    output logic               out_valid,
    input  logic               out_ready
);
    import frdt_pkg::*;

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;
    logic               hist_reg, hist_next;
    logic               bank_reg, bank_next;
    logic               repaint_reg, repaint_next;
    logic [CNT_W-1:0]   cnt_reg [2];
    logic [CNT_W-1:0]   cnt_next [2];
    logic               seen_reg [MAX_ENTITIES];
    logic               seen_next [MAX_ENTITIES];
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               match_reg, match_next;
    logic               changed_reg, changed_next;
    box_t               mbox_reg, mbox_next;
    result_t            pend_reg, pend_next;
    logic               pend_valid_reg, pend_valid_next;
    result_t            out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               ram_wr_en, ram_rd_en;
    logic [RAM_AW-1:0]  ram_wr_addr, ram_rd_addr;
    entry_t             ram_rd_data;

    logic               surf_ok, active, slot_free, cur, prev, ovf, emit;
    logic [CNT_W-1:0]   pc;
    box_t               ubox;
    result_t            r;

    frdt_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .clk    (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(item_reg.ent),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign surf_ok    = (surf.width != '0) && (surf.height != '0);
    assign active     = surf_ok && !repaint_reg;
    assign cur        = bank_reg;
    assign prev       = ~bank_reg;
    assign pc         = cnt_reg[prev];
    assign slot_free  = !out_valid_reg || out_ready;
    assign out_result = out_reg;
    assign out_valid  = out_valid_reg;

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        hist_next       = hist_reg;
        bank_next       = bank_reg;
        repaint_next    = repaint_reg;
        cnt_next        = cnt_reg;
        seen_next       = seen_reg;
        idx_next        = idx_reg;
        match_next      = match_reg;
        changed_next    = changed_reg;
        mbox_next       = mbox_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        q_pop           = 1'b0;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        ram_wr_addr     = {cur, cnt_reg[cur][IDX_W-1:0]};
        ram_rd_addr     = {prev, idx_reg[IDX_W-1:0]};
        ovf             = (cnt_reg[cur] >= CNT_W'(MAX_ENTITIES));
        emit            = 1'b0;
        ubox            = item_reg.ent.box;
        r               = clamp_box(item_reg.ent.box, surf);

        case (state_reg)
            ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop        = 1'b1;
                    item_next    = q_head;
                    hist_next    = hist_reg && surf_ok;
                    idx_next     = '0;
                    match_next   = 1'b0;
                    changed_next = 1'b0;
                    case (q_head.action)
                        ACT_BEGIN: begin
                            repaint_next  = q_head.repaint_all;
                            cnt_next[cur] = '0;
                            for (int i = 0; i < MAX_ENTITIES; i++) seen_next[i] = 1'b0;
                        end
                        ACT_HINT: state_next = ST_HINT;
                        ACT_CMD: begin
                            state_next = (hist_reg && surf_ok) ? ST_LOOK_RD : ST_CMD_FIN;
                        end
                        default: begin
                            pend_valid_next = 1'b0;
                            state_next = (active && hist_reg) ? ST_SW_RD : ST_END_FIN;
                        end
                    endcase
                end
            end
            ST_HINT: begin
                if (!(active && r.valid)) begin
                    state_next = ST_IDLE;
                end else if (slot_free) begin
                    out_next       = r;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_LOOK_RD: begin
                if (idx_reg < pc) begin
                    ram_rd_en  = 1'b1;
                    state_next = ST_LOOK_CMP;
                end else begin
                    state_next = ST_CMD_FIN;
                end
            end
            ST_LOOK_CMP: begin
                // Every matching entry is marked; only the first one is compared.
                if (ram_rd_data.key == item_reg.ent.key) begin
                    seen_next[idx_reg[IDX_W-1:0]] = 1'b1;
                    if (!match_reg) begin
                        match_next   = 1'b1;
                        mbox_next    = ram_rd_data.box;
                        changed_next = (ram_rd_data.box != item_reg.ent.box) ||
                                       (ram_rd_data.depth != item_reg.ent.depth) ||
                                       (ram_rd_data.kind != item_reg.ent.kind) ||
                                       (ram_rd_data.payload != item_reg.ent.payload) ||
                                       (ram_rd_data.opacity != item_reg.ent.opacity);
                    end
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_LOOK_RD;
            end
            ST_CMD_FIN: begin
                if (match_reg) begin
                    ubox.x0 = (mbox_reg.x0 < item_reg.ent.box.x0) ? mbox_reg.x0
                                                                   : item_reg.ent.box.x0;
                    ubox.y0 = (mbox_reg.y0 < item_reg.ent.box.y0) ? mbox_reg.y0
                                                                   : item_reg.ent.box.y0;
                    ubox.x1 = (mbox_reg.x1 > item_reg.ent.box.x1) ? mbox_reg.x1
                                                                   : item_reg.ent.box.x1;
                    ubox.y1 = (mbox_reg.y1 > item_reg.ent.box.y1) ? mbox_reg.y1
                                                                   : item_reg.ent.box.y1;
                end
                r    = clamp_box(ubox, surf);
                emit = active && (!match_reg || changed_reg) && r.valid;
                if (!(emit || ovf) || slot_free) begin
                    if (!ovf) begin
                        ram_wr_en     = 1'b1;
                        cnt_next[cur] = cnt_reg[cur] + 1'b1;
                    end
                    if (emit || ovf) begin
                        out_next       = emit ? r : '0;
                        out_next.valid = emit;
                        out_next.ovf   = ovf;
                        out_valid_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SW_RD: begin
                if (idx_reg < pc) begin
                    if (seen_reg[idx_reg[IDX_W-1:0]]) begin
                        idx_next = idx_reg + 1'b1;
                    end else begin
                        ram_rd_en  = 1'b1;
                        state_next = ST_SW_CMP;
                    end
                end else begin
                    state_next = ST_END_FIN;
                end
            end
            ST_SW_CMP: begin
                // One found box is held back so the final one can carry the last flag.
                r = clamp_box(ram_rd_data.box, surf);
                if (!r.valid) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SW_RD;
                end else if (!pend_valid_reg) begin
                    pend_next       = r;
                    pend_valid_next = 1'b1;
                    idx_next        = idx_reg + 1'b1;
                    state_next      = ST_SW_RD;
                end else if (slot_free) begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    pend_next      = r;
                    idx_next       = idx_reg + 1'b1;
                    state_next     = ST_SW_RD;
                end
            end
            ST_END_FIN: begin
                if (slot_free) begin
                    out_next       = pend_valid_reg ? pend_reg : '0;
                    out_next.last  = 1'b1;
                    out_valid_next = 1'b1;
                    bank_next      = prev;
                    cnt_next[prev] = '0;
                    for (int i = 0; i < MAX_ENTITIES; i++) seen_next[i] = 1'b0;
                    hist_next      = surf_ok;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hist_reg       <= 1'b0;
            bank_reg       <= 1'b0;
            repaint_reg    <= 1'b0;
            cnt_reg[0]     <= '0;
            cnt_reg[1]     <= '0;
            for (int i = 0; i < MAX_ENTITIES; i++) seen_reg[i] <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hist_reg       <= hist_next;
            bank_reg       <= bank_next;
            repaint_reg    <= repaint_next;
            cnt_reg        <= cnt_next;
            seen_reg       <= seen_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        idx_reg     <= idx_next;
        match_reg   <= match_next;
        changed_reg <= changed_next;
        mbox_reg    <= mbox_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

endmodule

// ===== src/frame_damage_rect_tracker_top.sv =====
// Top level of the frame damage rectangle tracker: ports, surface registers and wiring.
// Depends on frdt_pkg, frdt_front, frdt_queue and frdt_back.
//
//   channel  direction  handshake           contents
//   s_       in         s_tvalid/s_tready   frame items (begin, hint, command, end)
//   m_       out        m_tvalid/m_tready   dirty rectangles and frame markers
//   cfg_     in         cfg_valid/cfg_ready surface width (0) and height (1)
//
// A command with history reads each stored key of the previous bank from the
// single-read-port entity RAM and compares it in turn. An end item with a sweep skips
// each seen entry and reads each unseen one. Reset is synchronous and active low and
// needs no clearing pass. A stalled output blocks the sequencer only when it has a word
// to deliver; the queue keeps taking input until its four entries are full.
module frame_damage_rect_tracker_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // entity_key, rect_min_x, rect_min_y, rect_max_x, rect_max_y, depth_order,
    // command_kind, payload_ref, opacity_raw
    input  logic [frdt_pkg::IN_DATA_W-1:0]     s_tdata,
    // action, repaint_all
    input  logic [frdt_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // dirty_min_x, dirty_min_y, dirty_max_x, dirty_max_y
    output logic [frdt_pkg::OUT_DATA_W-1:0]    m_tdata,
    // rect_valid, table_overflow
    output logic [frdt_pkg::OUT_USER_W-1:0]    m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [frdt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [frdt_pkg::COORD_W-1:0]       cfg_data
);
    import frdt_pkg::*;

    surface_t surf_reg;
    item_t    front_item, q_head;
    logic     q_full, q_not_empty, q_pop;
    result_t  res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            surf_reg.width  <= WIDTH_RESET;
            surf_reg.height <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_SURFACE_WIDTH) begin
                surf_reg.width <= cfg_data;
            end else if (cfg_index == REG_SURFACE_HEIGHT) begin
                surf_reg.height <= cfg_data;
            end
        end
    end

    frdt_front u_front (
        .in_data(s_tdata),
        .in_user(s_tuser),
        .item   (front_item)
    );

    assign s_tready = !q_full;

    frdt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_tvalid && !q_full),
        .push_item(front_item),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head     (q_head)
    );

    frdt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .surf       (surf_reg),
        .q_not_empty(q_not_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_result (res),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

    assign m_tdata = {res.max_y, res.max_x, res.min_y, res.min_x};
    assign m_tuser = {res.ovf, res.valid};
    assign m_tlast = res.last;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of frame_damage_rect_tracker_top: random and directed frames,
// a behavioral predictor of the damage rectangles, and random stalls on both streams.
// Depends on frdt_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import frdt_pkg::*;

    typedef struct {
        action_t     act;
        bit          fr;
        bit [31:0]   key;
        bit [19:0]   ax, ay, bx, by;
        bit [31:0]   depth, payload;
        bit [7:0]    kind;
        bit [15:0]   opac;
    } frame_item_t;

    typedef struct {
        bit [13:0] x0, y0, x1, y1;
        bit        v, l, o;
    } damage_t;

    typedef struct { int x0, y0, x1, y1; } rect_t;

    typedef struct {
        bit [31:0] key;
        rect_t     box;
        bit [31:0] depth, payload;
        bit [7:0]  kind;
        bit [15:0] opac;
    } entity_t;

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [IN_USER_W-1:0] s_tuser = '0;
    logic m_tvalid, m_tready = 0, m_tlast;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic cfg_valid = 0, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0] cfg_data = '0;

    frame_damage_rect_tracker_top uut (.*);

    always #1 aclk = ~aclk;

    frame_item_t pend_items[$];
    damage_t     exp_damage[$];
    frame_item_t cur_item;
    int errors = 0;
    bit quiet = 0;
    bit hold_go = 0;

    // Predictor state.
    int surf_w = 1920, surf_h = 1080;
    entity_t bank[2][MAX_ENTITIES];
    int  cnt[2] = '{0, 0};
    bit  seen[MAX_ENTITIES];
    bit  hist = 0, sel = 0, rep = 0;

    function automatic void add_item(frame_item_t it);
        pend_items = {pend_items, it};
    endfunction

    function automatic int sat_edge(int v);
        return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
    endfunction

    function automatic rect_t item_rect(frame_item_t it);
        int ax, ay, bx, by;
        rect_t r;
        ax = int'($signed(it.ax)); ay = int'($signed(it.ay));
        bx = int'($signed(it.bx)); by = int'($signed(it.by));
        r.x0 = (ax < bx ? ax : bx) >>> FRACTION_BITS;
        r.y0 = (ay < by ? ay : by) >>> FRACTION_BITS;
        r.x1 = ((ax > bx ? ax : bx) + 15) >>> FRACTION_BITS;
        r.y1 = ((ay > by ? ay : by) + 15) >>> FRACTION_BITS;
        return r;
    endfunction

    function automatic int clampv(int v, int hi);
        return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    function automatic rect_t clip(rect_t r);
        rect_t c;
        c.x0 = clampv(r.x0, surf_w); c.x1 = clampv(r.x1, surf_w);
        c.y0 = clampv(r.y0, surf_h); c.y1 = clampv(r.y1, surf_h);
        return c;
    endfunction

    function automatic bit nonempty(rect_t r);
        return r.x1 > r.x0 && r.y1 > r.y0;
    endfunction

    function automatic bit same_rect(rect_t a, rect_t b);
        return a.x0 == b.x0 && a.y0 == b.y0 && a.x1 == b.x1 && a.y1 == b.y1;
    endfunction

    function automatic void push_damage(rect_t r, bit v, bit l, bit o);
        damage_t d;
        d.x0 = v ? r.x0[13:0] : '0; d.y0 = v ? r.y0[13:0] : '0;
        d.x1 = v ? r.x1[13:0] : '0; d.y1 = v ? r.y1[13:0] : '0;
        d.v = v; d.l = l; d.o = o;
        exp_damage = {exp_damage, d};
    endfunction

    function automatic void predict_damage(frame_item_t it);
        int cur, prv, pc, match, n;
        bit ok, act, emit, ovf;
        entity_t e;
        rect_t r, nb, c;
        cur = sel; prv = !sel;
        ok = surf_w != 0 && surf_h != 0;
        act = ok && !rep;
        if (!ok) hist = 0;
        pc = cnt[prv];
        case (it.act)
            ACT_BEGIN: begin
                rep = it.fr;
                cnt[cur] = 0;
                seen = '{default: 0};
            end
            ACT_HINT: begin
                c = clip(item_rect(it));
                if (act && nonempty(c)) push_damage(c, 1, 0, 0);
            end
            ACT_CMD: begin
                nb = item_rect(it);
                e.key = it.key;
                e.box.x0 = sat_edge(nb.x0); e.box.y0 = sat_edge(nb.y0);
                e.box.x1 = sat_edge(nb.x1); e.box.y1 = sat_edge(nb.y1);
                e.depth = it.depth; e.kind = it.kind; e.payload = it.payload; e.opac = it.opac;
                match = -1; emit = 0; ovf = 0;
                if (hist) begin
                    for (int i = 0; i < pc; i++) begin
                        if (bank[prv][i].key == e.key) begin
                            seen[i] = 1;
                            if (match < 0) match = i;
                        end
                    end
                end
                r = e.box;
                if (act) begin
                    if (match >= 0) begin
                        entity_t p;
                        p = bank[prv][match];
                        if (!same_rect(p.box, e.box) || p.depth != e.depth ||
                            p.kind != e.kind || p.payload != e.payload ||
                            p.opac != e.opac) begin
                            r.x0 = p.box.x0 < e.box.x0 ? p.box.x0 : e.box.x0;
                            r.y0 = p.box.y0 < e.box.y0 ? p.box.y0 : e.box.y0;
                            r.x1 = p.box.x1 > e.box.x1 ? p.box.x1 : e.box.x1;
                            r.y1 = p.box.y1 > e.box.y1 ? p.box.y1 : e.box.y1;
                            r = clip(r);
                            emit = nonempty(r);
                        end
                    end else begin
                        r = clip(r);
                        emit = nonempty(r);
                    end
                end
                if (cnt[cur] < MAX_ENTITIES) begin
                    bank[cur][cnt[cur]] = e;
                    cnt[cur]++;
                end else begin
                    ovf = 1;
                end
                if (emit || ovf) push_damage(r, emit, 0, ovf);
            end
            default: begin
                n = 0;
                if (act && hist) begin
                    for (int i = 0; i < pc; i++) begin
                        c = clip(bank[prv][i].box);
                        if (!seen[i] && nonempty(c)) begin
                            push_damage(c, 1, 0, 0);
                            n++;
                        end
                    end
                end
                if (n > 0) exp_damage[exp_damage.size()-1].l = 1;
                else push_damage('{0, 0, 0, 0}, 0, 1, 0);
                sel = prv;
                cnt[prv] = 0;
                seen = '{default: 0};
                hist = ok;
            end
        endcase
    endfunction

    // Input driver.
    int tx_idle = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) predict_damage(cur_item);
            if (!s_tvalid || s_tready) begin
                if (tx_idle > 0) begin
                    tx_idle <= tx_idle - 1;
                    s_tvalid <= 0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    tx_idle <= $urandom_range(1, 18) - 1;
                    s_tvalid <= 0;
                end else if (pend_items.size() > 0) begin
                    frame_item_t it;
                    it = pend_items.pop_front();
                    cur_item <= it;
                    s_tdata <= {it.opac, it.payload, it.kind, it.depth,
                                it.by, it.bx, it.ay, it.ax, it.key};
                    s_tuser <= {it.fr, it.act};
                    s_tvalid <= 1;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    task automatic report(string what, int want, int got);
        $display("mismatch %s: expected %0d, got %0d", what, want, got);
        errors++;
    endtask

    // Result monitor and receiver stalls.
    int rx_idle = 0, rx_hold = 0;
    bit hold_used = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (exp_damage.size() == 0) begin
                    report("result words pending", 0, 1);
                end else begin
                    damage_t w;
                    w = exp_damage.pop_front();
                    if (m_tdata[13:0] != w.x0) report("dirty_min_x", w.x0, m_tdata[13:0]);
                    if (m_tdata[27:14] != w.y0) report("dirty_min_y", w.y0, m_tdata[27:14]);
                    if (m_tdata[41:28] != w.x1) report("dirty_max_x", w.x1, m_tdata[41:28]);
                    if (m_tdata[55:42] != w.y1) report("dirty_max_y", w.y1, m_tdata[55:42]);
                    if (m_tuser[0] != w.v) report("rect_valid", w.v, m_tuser[0]);
                    if (m_tuser[1] != w.o) report("table_overflow", w.o, m_tuser[1]);
                    if (m_tlast != w.l) report("last_of_frame", w.l, m_tlast);
                end
            end
            if (hold_go && !hold_used) begin
                hold_used <= 1;
                rx_hold <= 600;
                m_tready <= 0;
            end else if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                m_tready <= 0;
            end else if (rx_idle > 0) begin
                rx_idle <= rx_idle - 1;
                m_tready <= 0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rx_idle <= $urandom_range(1, 18) - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    int stuck = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck > 20000) begin
            $display("frame_damage_rect_tracker_top verification failed");
            $finish;
        end
    end

    // Stimulus helpers.
    bit [31:0] pool_key[12], pool_depth[12], pool_payload[12];
    bit [7:0]  pool_kind[12];
    bit [15:0] pool_opac[12];
    bit [19:0] pool_c[12][4];

    function automatic frame_item_t mk(action_t a, bit fr = 0);
        frame_item_t it;
        it.act = a; it.fr = fr; it.key = $urandom();
        it.ax = 20'($urandom()); it.ay = 20'($urandom());
        it.bx = 20'($urandom()); it.by = 20'($urandom());
        it.depth = $urandom(); it.payload = $urandom();
        it.kind = 8'($urandom()); it.opac = 16'($urandom());
        return it;
    endfunction

    function automatic bit [19:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return 20'($urandom());
        return 20'(int'($urandom_range(0, 2300)) * 16 - 800 + int'($urandom_range(0, 15)));
    endfunction

    function automatic frame_item_t mk_hint(bit [19:0] ax, ay, bx, by);
        frame_item_t it;
        it = mk(ACT_HINT);
        it.ax = ax; it.ay = ay; it.bx = bx; it.by = by;
        return it;
    endfunction

    function automatic frame_item_t pool_cmd(int k);
        frame_item_t it;
        it = mk(ACT_CMD);
        it.key = pool_key[k]; it.depth = pool_depth[k]; it.payload = pool_payload[k];
        it.kind = pool_kind[k]; it.opac = pool_opac[k];
        it.ax = pool_c[k][0]; it.ay = pool_c[k][1]; it.bx = pool_c[k][2]; it.by = pool_c[k][3];
        return it;
    endfunction

    function automatic void new_pool(int k);
        pool_key[k] = $urandom(); pool_depth[k] = $urandom(); pool_payload[k] = $urandom();
        pool_kind[k] = 8'($urandom()); pool_opac[k] = 16'($urandom());
        for (int j = 0; j < 4; j++) pool_c[k][j] = rand_coord();
    endfunction

    function automatic void mutate_pool(int k);
        case ($urandom_range(0, 4))
            0: pool_c[k][$urandom_range(0, 3)] = rand_coord();
            1: pool_depth[k] = $urandom();
            2: pool_kind[k] = 8'($urandom());
            3: pool_payload[k] = $urandom();
            default: pool_opac[k] = 16'($urandom());
        endcase
    endfunction

    task automatic gen_frame(int n);
        int k;
        add_item(mk(ACT_BEGIN, $urandom_range(0, 7) == 0));
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_item(mk_hint(rand_coord(), rand_coord(),
                                          rand_coord(), rand_coord()));
                9: add_item(mk(action_t'($urandom_range(0, 3)), 1'($urandom())));
                default: begin
                    k = $urandom_range(0, 11);
                    if ($urandom_range(0, 9) == 0) new_pool(k);
                    else if ($urandom_range(0, 3) == 0) mutate_pool(k);
                    add_item(pool_cmd(k));
                end
            endcase
        end
        if ($urandom_range(0, 9) != 0) add_item(mk(ACT_END));
    endtask

    task automatic drain();
        while (pend_items.size() > 0 || s_tvalid || exp_damage.size() > 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_index <= idx;
        cfg_data <= val[COORD_W-1:0];
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_SURFACE_WIDTH) surf_w = val;
        else surf_h = val;
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic set_surface(int w, int h);
        write_reg(REG_SURFACE_WIDTH, w);
        write_reg(REG_SURFACE_HEIGHT, h);
    endtask

    initial begin
        frame_item_t it;
        for (int k = 0; k < 12; k++) new_pool(k);
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: hint extremes, new, unchanged, changed and vanished entities.
        add_item(mk(ACT_BEGIN, 0));
        add_item(mk_hint(20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF));
        add_item(mk_hint(20'd320, 20'd480, 20'd161, 20'd17));
        add_item(mk_hint(20'd800, 20'd800, 20'd800, 20'd800));
        add_item(mk_hint(20'hFFFF1, 20'hFFFF1, 20'h00000, 20'h00000));
        add_item(mk_hint(20'h80000, 20'h7FFFF, 20'h7FFFF, 20'h80000));
        for (int k = 0; k < 3; k++) begin
            pool_c[k][0] = 20'(160 * (k + 1)); pool_c[k][1] = 20'd100;
            pool_c[k][2] = 20'(160 * (k + 2)); pool_c[k][3] = 20'd900;
            add_item(pool_cmd(k));
        end
        it = mk(ACT_CMD);
        it.ax = 20'h7FFFF; it.bx = 20'h7FFF0; it.ay = 20'h80000; it.by = 20'h80010;
        add_item(it);
        add_item(mk(ACT_END));
        add_item(mk(ACT_BEGIN, 0));
        add_item(pool_cmd(0));
        pool_opac[1] = ~pool_opac[1];
        add_item(pool_cmd(1));
        add_item(pool_cmd(1));
        add_item(mk(ACT_END));
        // Full repaint, missing begin and a repeated begin.
        add_item(mk(ACT_BEGIN, 1));
        add_item(pool_cmd(2));
        add_item(mk_hint(20'd0, 20'd0, 20'd4000, 20'd4000));
        add_item(mk(ACT_END));
        add_item(pool_cmd(0));
        add_item(mk(ACT_END));
        add_item(mk(ACT_BEGIN, 0));
        add_item(pool_cmd(1));
        add_item(mk(ACT_BEGIN, 0));
        add_item(mk(ACT_END));
        drain();

        // Table overflow, with the receiver held off long enough to back up the input.
        add_item(mk(ACT_BEGIN, 0));
        for (int i = 0; i < MAX_ENTITIES + 3; i++) begin
            it = mk(ACT_CMD);
            it.ax = 20'($urandom_range(0, 1900 * 16)); it.ay = 20'($urandom_range(0, 1000 * 16));
            it.bx = it.ax + 20'd64; it.by = it.ay + 20'd64;
            add_item(it);
        end
        add_item(mk(ACT_END));
        @(posedge aclk);
        hold_go <= 1;
        for (int f = 0; f < 3; f++) gen_frame($urandom_range(4, 10));
        drain();

        set_surface(16383, 16383);
        for (int f = 0; f < 4; f++) gen_frame($urandom_range(3, 10));
        drain();
        set_surface(0, 16383);
        for (int f = 0; f < 3; f++) gen_frame($urandom_range(3, 8));
        drain();
        set_surface(8192, 8192);
        for (int f = 0; f < 4; f++) gen_frame($urandom_range(3, 10));
        drain();
        set_surface(640, 0);
        for (int f = 0; f < 2; f++) gen_frame($urandom_range(3, 8));
        drain();
        set_surface(1, 1);
        for (int f = 0; f < 2; f++) gen_frame($urandom_range(3, 8));
        drain();
        set_surface(1920, 1080);
        for (int f = 0; f < 3; f++) gen_frame($urandom_range(3, 10));
        while (pend_items.size() > 0) @(posedge aclk);
        quiet = 1;
        for (int f = 0; f < 3; f++) gen_frame($urandom_range(3, 10));
        drain();

        if (errors == 0) begin
            $display("frame_damage_rect_tracker_top verification clean");
        end else begin
            $display("frame_damage_rect_tracker_top verification failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/frdt_pkg.sv
src/frdt_ram.sv
src/frdt_front.sv
src/frdt_queue.sv
src/frdt_back.sv
src/frame_damage_rect_tracker_top.sv
tb/sv/tb.sv
